// ----- rtl/blank_run_to_tab_converter_core_defines.svh -----
// Assertion macros for the blank-run to tab converter.
// Used at the end of the top level; no other dependencies.
`ifndef BLANK_RUN_TO_TAB_CONVERTER_CORE_DEFINES_SVH
`define BLANK_RUN_TO_TAB_CONVERTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BRTC_ASSERT_IMPLIES(label, clk_i, rst_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("brtc assertion failed");
`define BRTC_ASSERT_NEXT(label, clk_i, rst_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("brtc assertion failed");
`else
`define BRTC_ASSERT_IMPLIES(label, clk_i, rst_i, ante, cons)
`define BRTC_ASSERT_NEXT(label, clk_i, rst_i, ante, cons)
`endif
`endif

// ----- rtl/brtc_pkg.sv -----
// Shared types and constants of the blank-run to tab converter.
// No dependencies; imported by every module of the block.
`default_nettype none
package brtc_pkg;

  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int STOP_W = 6;
  localparam int CIS_W  = 5;
  localparam int TW_W   = 6;

  localparam logic [TW_W-1:0] TAB_W_MIN   = 6'd4;
  localparam logic [TW_W-1:0] TAB_W_MAX   = 6'd32;
  localparam logic [TW_W-1:0] TAB_W_RESET = 6'd8;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  // One queued byte with the tabs and spaces that precede it.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [STOP_W-1:0] tabs;
    logic [COL_W-1:0]  spaces;
  } brtc_cmd_t;

  typedef struct packed {
    logic              start;
    logic [TW_W-1:0]   divisor;
    logic [COL_W-1:0]  num_a;
    logic [COL_W-1:0]  num_b;
  } brtc_div_req_t;

  typedef struct packed {
    logic              done;
    logic [STOP_W-1:0] quot_a;
    logic [CIS_W-1:0]  rem_a;
    logic [STOP_W-1:0] quot_b;
  } brtc_div_res_t;

endpackage
`default_nettype wire

// ----- rtl/blank_run_to_tab_converter_core.sv -----
// Blank-run to tab converter: one byte per cycle in while in_ready is high; a taken byte
// goes through the queue and the output register; a byte that closes a blank run first
// sends its tabs and spaces, one per cycle with out_ready high. Spaces are not queued.
// A tab_width write pauses input while the serial divider rebuilds the tab stop position.
// Synchronous active-high reset clears column, run state and queue; tab width becomes 8.
`default_nettype none
`include "blank_run_to_tab_converter_core_defines.svh"
module blank_run_to_tab_converter_core #(
  parameter int LINE_MAX    = 128,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [brtc_pkg::TW_W-1:0]     tab_width,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [brtc_pkg::CHAR_W-1:0]   in_char,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [brtc_pkg::CHAR_W-1:0]        out_char,
  output logic                               last
);
  import brtc_pkg::*;

  brtc_div_req_t div_req;
  brtc_div_res_t div_res;
  brtc_cmd_t     push_data, head;
  logic          push, pop, empty, full, recalc, active;
  logic          is_fill;

  brtc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  brtc_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .tab_width (tab_width),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .div_req   (div_req),
    .div_res   (div_res),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .recalc    (recalc)
  );

  brtc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  brtc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last),
    .active    (active)
  );

  assign is_fill = (out_char == CH_TAB) || (out_char == CH_SPACE);

  `BRTC_ASSERT_IMPLIES(a_done_in_recalc, clk, rst, div_res.done, recalc)
  `BRTC_ASSERT_NEXT(a_recalc_ends, clk, rst, div_res.done, !recalc)
  `BRTC_ASSERT_IMPLIES(a_active_has_out, clk, rst, active, out_valid)
  `BRTC_ASSERT_IMPLIES(a_fill_is_blank, clk, rst, out_valid && !last, active && is_fill)

endmodule
`default_nettype wire

// ----- rtl/brtc_div.sv -----
// Serial restoring divider: two dividends over one shared divisor, one bit a cycle.
// Depends on brtc_pkg.
`default_nettype none
module brtc_div (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire brtc_pkg::brtc_div_req_t req,
  output brtc_pkg::brtc_div_res_t     res
);
  import brtc_pkg::*;

  localparam int CNT_W = $clog2(COL_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(COL_W - 1);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [TW_W-1:0]   divisor;
  logic [COL_W-1:0]  na, nb;
  logic [TW_W-1:0]   ra, rb;
  logic [COL_W-1:0]  qa, qb;

  logic [COL_W-1:0]  sa, sb;
  logic              ge_a, ge_b;
  logic [TW_W-1:0]   ra_next, rb_next;

  always_comb begin
    sa      = {ra, na[COL_W-1]};
    sb      = {rb, nb[COL_W-1]};
    ge_a    = sa >= {1'b0, divisor};
    ge_b    = sb >= {1'b0, divisor};
    ra_next = ge_a ? TW_W'(sa - {1'b0, divisor}) : TW_W'(sa);
    rb_next = ge_b ? TW_W'(sb - {1'b0, divisor}) : TW_W'(sb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      na      <= req.num_a;
      nb      <= req.num_b;
      ra      <= '0;
      rb      <= '0;
      qa      <= '0;
      qb      <= '0;
    end else if (busy) begin
      na <= {na[COL_W-2:0], 1'b0};
      nb <= {nb[COL_W-2:0], 1'b0};
      ra <= ra_next;
      rb <= rb_next;
      qa <= {qa[COL_W-2:0], ge_a};
      qb <= {qb[COL_W-2:0], ge_b};
    end
  end

  assign res.done   = done;
  assign res.quot_a = qa[STOP_W-1:0];
  assign res.rem_a  = ra[CIS_W-1:0];
  assign res.quot_b = qb[STOP_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/brtc_fifo.sv -----
// Short command queue between the front and back parts, show-ahead read.
// Depends on brtc_pkg.
`default_nettype none
module brtc_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire brtc_pkg::brtc_cmd_t push_data,
  input  wire logic              pop,
  output brtc_pkg::brtc_cmd_t    head,
  output logic                   empty,
  output logic                   full
);
  import brtc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  brtc_cmd_t         mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [PTR_W:0]    count;
  logic              do_push, do_pop;

  assign empty   = count == '0;
  assign full    = count == (PTR_W+1)'(DEPTH);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/brtc_front.sv -----
// Front part: takes bytes, tracks column and tab stops, turns each
// non-space byte into a queue command. Depends on brtc_pkg.
`default_nettype none
module brtc_front #(
  parameter int LINE_MAX = 128
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [brtc_pkg::TW_W-1:0] tab_width,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [brtc_pkg::CHAR_W-1:0] in_char,
  output brtc_pkg::brtc_div_req_t        div_req,
  input  wire brtc_pkg::brtc_div_res_t   div_res,
  output logic                           push,
  output brtc_pkg::brtc_cmd_t            push_data,
  input  wire logic                      full,
  output logic                           recalc
);
  import brtc_pkg::*;

  localparam logic [COL_W-1:0] RESTART_COL = COL_W'(LINE_MAX - 1);

  logic [TW_W-1:0]   w_eff;
  logic [COL_W-1:0]  column;
  logic [CIS_W-1:0]  cis;
  logic [STOP_W-1:0] stop;
  logic              in_run;
  logic [COL_W-1:0]  run_col;
  logic [STOP_W-1:0] run_stop;

  logic [TW_W-1:0]   w_sat;
  logic              cfg_fire, in_fire, is_space, crossed, restart, wrap;
  logic [COL_W-1:0]  col_inc;
  logic [TW_W-1:0]   cis_inc;
  logic [STOP_W-1:0] tabs;
  logic [COL_W-1:0]  spaces;

  always_comb begin
    priority if (tab_width < TAB_W_MIN) w_sat = TAB_W_MIN;
    else if (tab_width > TAB_W_MAX)     w_sat = TAB_W_MAX;
    else                                w_sat = tab_width;
  end

  // Hold input while a width write is pending so both never land on one edge.
  assign cfg_ready = !rst && !recalc;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = !rst && !recalc && !full && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign is_space  = in_char == CH_SPACE;
  assign crossed   = stop > run_stop;

  // Tabs for each stop crossed, then spaces from the last stop; else spaces for the run.
  always_comb begin
    tabs   = '0;
    spaces = '0;
    if (in_run) begin
      if (crossed) begin
        tabs   = stop - run_stop;
        spaces = COL_W'(cis);
      end else if (column >= run_col) begin
        spaces = column - run_col;
      end
    end
  end

  assign push             = in_fire && !is_space;
  assign push_data.ch     = in_char;
  assign push_data.tabs   = tabs;
  assign push_data.spaces = spaces;

  assign col_inc = column + 1'b1;
  assign cis_inc = {1'b0, cis} + 1'b1;
  assign wrap    = cis_inc == w_eff;
  assign restart = (in_char == CH_NL) || (col_inc >= RESTART_COL);

  assign div_req.start   = cfg_fire;
  assign div_req.divisor = w_sat;
  assign div_req.num_a   = column;
  assign div_req.num_b   = run_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff    <= TAB_W_RESET;
      column   <= '0;
      cis      <= '0;
      stop     <= '0;
      in_run   <= 1'b0;
      run_col  <= '0;
      run_stop <= '0;
      recalc   <= 1'b0;
    end else begin
      if (cfg_fire) begin
        w_eff  <= w_sat;
        recalc <= 1'b1;
      end
      // Rebuild stop positions for the new width.
      if (div_res.done) begin
        cis      <= div_res.rem_a;
        stop     <= div_res.quot_a;
        run_stop <= div_res.quot_b;
        recalc   <= 1'b0;
      end
      if (in_fire) begin
        if (is_space && !in_run) begin
          run_col  <= column;
          run_stop <= stop;
        end
        in_run <= is_space && !restart;
        if (restart) begin
          column <= '0;
          cis    <= '0;
          stop   <= '0;
        end else begin
          column <= col_inc;
          if (wrap) begin
            cis  <= '0;
            stop <= stop + 1'b1;
          end else begin
            cis <= CIS_W'(cis_inc);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/brtc_back.sv -----
// Back part: expands queue commands into tabs, spaces and the byte itself,
// into a registered output stage. Depends on brtc_pkg.
`default_nettype none
module brtc_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire brtc_pkg::brtc_cmd_t           head,
  input  wire logic                          empty,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [brtc_pkg::CHAR_W-1:0]        out_char,
  output logic                               last,
  output logic                               active
);
  import brtc_pkg::*;

  brtc_cmd_t          held, cur, held_next;
  logic               cur_valid, load, active_next, last_next;
  logic [CHAR_W-1:0]  char_next;

  assign cur       = active ? held : head;
  assign cur_valid = active || !empty;
  assign load      = cur_valid && (!out_valid || out_ready);
  assign pop       = load && !active;

  always_comb begin
    held_next = cur;
    priority if (cur.tabs != '0) begin
      char_next      = CH_TAB;
      last_next      = 1'b0;
      active_next    = 1'b1;
      held_next.tabs = cur.tabs - 1'b1;
    end else if (cur.spaces != '0) begin
      char_next        = CH_SPACE;
      last_next        = 1'b0;
      active_next      = 1'b1;
      held_next.spaces = cur.spaces - 1'b1;
    end else begin
      char_next   = cur.ch;
      last_next   = 1'b1;
      active_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      active    <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      active    <= active_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held     <= held_next;
      out_char <= char_next;
      last     <= last_next;
    end
  end

endmodule
`default_nettype wire
